[rtl/bafir_pkg.sv]
// shared constants, coefficient table and lookup for the byte audio fir
package bafir_pkg;

  localparam int unsigned DefTaps   = 24;
  localparam int unsigned CoefCount = 24;
  localparam int unsigned CoefSelW  = $clog2(CoefCount);
  localparam int unsigned CoefIdxW  = 8;   // covers up to 256 taps
  localparam int unsigned CoefW     = 11;
  localparam int unsigned SampW     = 9;
  localparam int unsigned ProdW     = CoefW + SampW;
  localparam int unsigned AccW      = 24;
  localparam int unsigned ByteW     = 8;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [SampW-1:0] samp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // q16 coefficients, newest sample first
  localparam coef_t CoefTable [CoefCount] = '{
    11'sd409,  11'sd296,  11'sd0,    -11'sd308, -11'sd446, -11'sd322, -11'sd1,   11'sd338,
    11'sd489,  11'sd355,  11'sd0,    -11'sd372, -11'sd541, -11'sd393, -11'sd1,   11'sd416,
    11'sd605,  11'sd442,  11'sd0,    -11'sd469, -11'sd687, -11'sd502, -11'sd1,   11'sd540
  };

  // taps past the table weigh zero
  function automatic coef_t coef_at(input logic [CoefIdxW-1:0] idx);
    coef_t c;
    c = '0;
    if (idx < CoefIdxW'(CoefCount)) begin
      c = CoefTable[idx[CoefSelW-1:0]];
    end
    return c;
  endfunction

endpackage

[rtl/bafir_scale.sv]
// output scaling: floor(acc / (255 * 512)) + 128, clamped to a byte
module bafir_scale (
  input  bafir_pkg::acc_t             acc_i,
  output logic [bafir_pkg::ByteW-1:0] byte_o
);
  import bafir_pkg::*;

  localparam int unsigned Shift = 9;
  localparam int unsigned ShW   = AccW - Shift;

  logic signed [ShW-1:0] a_sh;
  logic                  neg;
  logic [ShW-1:0]        mag;
  logic [ShW:0]          est;
  logic [ByteW-1:0]      q_mag;
  logic signed [ByteW:0] q;
  logic signed [ByteW+1:0] y;

  always_comb begin
    // arithmetic shift floors, so floor division nests cleanly
    a_sh = ShW'(acc_i >>> Shift);
    neg  = a_sh[ShW-1];
    // floor(a / 255) = ~floor(~a / 255) for negative a
    mag  = neg ? ~a_sh : a_sh;
    // n / 255 = (n + (n >> 8) + 1) >> 8, exact for quotients below 256
    est  = {1'b0, mag} + (ShW+1)'(mag >> 8) + (ShW+1)'(1);
    q_mag = est[ByteW +: ByteW];
    q    = neg ? ~{1'b0, q_mag} : {1'b0, q_mag};
    y    = {q[ByteW], q} + (ByteW+2)'(128);
    if (y < 0) begin
      byte_o = '0;
    end else if (y > (ByteW+2)'(255)) begin
      byte_o = '1;
    end else begin
      byte_o = y[ByteW-1:0];
    end
  end

endmodule

[rtl/byte_audio_fir_24tap.sv]
// top level of the byte audio fir filter with its delay line memory
// Direct-form FIR on unsigned 8-bit audio. Each input transfer carries one byte d,
// turned into the offset s = 2d - 255 and written into a circular delay line held
// in a single-port-read synchronous memory. The block then reads one tap per cycle,
// newest first, multiplies by a fixed q16 coefficient and accumulates, so an item
// occupies the memory read port for one read per tap; its sum then passes the
// finished-sum register and the output register. A new byte can be taken in the
// cycle after the previous one has issued its last read, if a result slot is free,
// while that item's tail is still in the multiply and
// accumulate stages; up to two finished results can wait for the output side. Each
// result is floor(acc / (255 * 512)) + 128, saturated to 0..255; tlast rides along
// unchanged. Delay line entries read as zero until first written after reset.
module byte_audio_fir_24tap #(
  parameter int unsigned Taps = bafir_pkg::DefTaps  // 2 .. 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bafir_pkg::ByteW-1:0]  s_axis_tdata_i,   // [7:0] sample_byte
  input  logic                         s_axis_tlast_i,   // last_in
  // output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bafir_pkg::ByteW-1:0]  m_axis_tdata_o,   // [7:0] filtered_byte
  output logic                         m_axis_tlast_o    // last_out
);
  import bafir_pkg::*;

  localparam int unsigned AddrW = $clog2(Taps);

  typedef struct packed {
    logic first;  // first tap of an item, restarts the sum
    logic last;   // last tap of an item, closes the sum
    logic tlast;  // frame marker of the item
  } tap_tag_t;

  // input transfer and occupancy
  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] cnt_q, cnt_d;   // items accepted but not yet delivered

  // delay line storage
  samp_t              dline_mem [Taps];
  logic [Taps-1:0]    valid_q;
  samp_t              samp_in;
  samp_t              rdata_q;

  // read sequencer
  logic             busy_q;
  logic [AddrW-1:0] wp_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [AddrW-1:0] tap_cnt_q;
  logic             item_last_q;
  logic             tap_final;

  // stage 1: read data and coefficient
  logic     s1_vld_q;
  tap_tag_t s1_tag_q;
  logic     s1_ok_q;
  coef_t    coef_q;
  samp_t    s1_samp;

  // stage 2: product
  logic     s2_vld_q;
  tap_tag_t s2_tag_q;
  prod_t    prod_q;

  // accumulator and finished sum
  acc_t acc_q;
  acc_t acc_sum;
  logic acc_done;
  logic fin_vld_q;
  logic fin_last_q;
  acc_t fin_acc_q;
  logic fin_to_out;
  logic [ByteW-1:0] fin_byte;

  // output register
  logic             out_vld_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_last_q;

  // accept while no read sweep runs and a result slot is free
  assign s_axis_tready_o = !busy_q && (cnt_q < 2'd2);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = out_vld_q && m_axis_tready_i;

  // 2d - 255 is (2d + 1) - 256: flip the top bit of {d, 1}
  assign samp_in = {~s_axis_tdata_i[ByteW-1], s_axis_tdata_i[ByteW-2:0], 1'b1};

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // delay line memory; the write happens in the accept cycle and reads start
  // on the next cycle, so the newest sample is already visible without bypass
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dline_mem[wp_q] <= samp_in;
    end
    if (busy_q) begin
      rdata_q <= dline_mem[rd_addr_q];
    end
  end

  assign tap_final = (tap_cnt_q == AddrW'(Taps - 1));

  // sequencer: one read per cycle, walking back from the newest entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      wp_q        <= '0;
      rd_addr_q   <= '0;
      tap_cnt_q   <= '0;
      item_last_q <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        valid_q[wp_q] <= 1'b1;
        busy_q        <= 1'b1;
        rd_addr_q     <= wp_q;
        tap_cnt_q     <= '0;
        item_last_q   <= s_axis_tlast_i;
        wp_q          <= (wp_q == AddrW'(Taps - 1)) ? '0 : wp_q + AddrW'(1);
      end else if (busy_q) begin
        rd_addr_q <= (rd_addr_q == '0) ? AddrW'(Taps - 1) : rd_addr_q - AddrW'(1);
        tap_cnt_q <= tap_cnt_q + AddrW'(1);
        if (tap_final) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // stage 1 and stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= busy_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      s1_tag_q <= '{first: (tap_cnt_q == '0), last: tap_final, tlast: item_last_q};
      s1_ok_q  <= valid_q[rd_addr_q];
      coef_q   <= coef_at(CoefIdxW'(tap_cnt_q));
    end
  end

  // unwritten entries count as zero
  assign s1_samp = s1_ok_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_tag_q <= s1_tag_q;
      prod_q   <= coef_q * s1_samp;
    end
  end

  assign acc_sum  = s2_tag_q.first ? AccW'(prod_q) : acc_q + AccW'(prod_q);
  assign acc_done = s2_vld_q && s2_tag_q.last;

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= acc_sum;
    end
    if (acc_done) begin
      fin_acc_q  <= acc_sum;
      fin_last_q <= s2_tag_q.tlast;
    end
  end

  assign fin_to_out = fin_vld_q && (!out_vld_q || m_axis_tready_i);

  bafir_scale u_scale (
    .acc_i  (fin_acc_q),
    .byte_o (fin_byte)
  );

  // finished sum and output register valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc_done) begin
        fin_vld_q <= 1'b1;
      end else if (fin_to_out) begin
        fin_vld_q <= 1'b0;
      end
      if (fin_to_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_to_out) begin
      out_data_q <= fin_byte;
      out_last_q <= fin_last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // occupancy never goes past the two result slots
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("too many items in flight");

  // a closing sum never lands on a finished sum that cannot move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done && fin_vld_q |-> fin_to_out)
    else $error("finished sum overwritten");

  // with nothing outstanding, no result is held anywhere
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !out_vld_q && !fin_vld_q && !busy_q)
    else $error("result held with no item outstanding");

  // a read sweep only starts from an accepted transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(in_xfer) && tap_cnt_q == '0)
    else $error("read sweep started without a transfer");

endmodule

[sim/tb.sv]
// testbench for the 24-tap byte audio fir filter: directed table plus random runs with a predictor
`timescale 1ns / 1ps

module tb;

  import bafir_pkg::*;

  localparam int unsigned Taps       = 24;
  localparam int unsigned RandItems  = 450;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 4 * Taps + 16;
  localparam longint     OutDiv     = 130560;  // 255 * 65536 / 128
  localparam int          IdlePct    = 9;

  // q16 coefficients, index 0 weighs the newest sample
  localparam int FirCoef [Taps] = '{
    409, 296, 0, -308, -446, -322, -1, 338,
    489, 355, 0, -372, -541, -393, -1, 416,
    605, 442, 0, -469, -687, -502, -1, 540
  };

  typedef struct packed {
    logic [ByteW-1:0] filtered_byte;
    logic             last_out;
  } fir_out_t;

  // one row of the directed table; exp_byte is used only where has_exp is set
  typedef struct {
    logic [ByteW-1:0] sample_byte;
    logic             last_in;
    bit               has_exp;
    logic [ByteW-1:0] exp_byte;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [ByteW-1:0] s_axis_tdata_i;   // [7:0] sample_byte
  logic             s_axis_tlast_i;   // last_in
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [ByteW-1:0] m_axis_tdata_o;   // [7:0] filtered_byte
  logic             m_axis_tlast_o;   // last_out

  // predictor state: its own copy of the delay line and write slot
  samp_t       sample_history [Taps];
  int unsigned history_slot;

  fir_out_t    expected_bytes [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          stall_enable;

  byte_audio_fir_24tap #(
    .Taps (Taps)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // map the byte to its offset, shift it in, convolve and rescale with a true floor
  function automatic fir_out_t fir_filter_step(input logic [ByteW-1:0] b, input logic last);
    longint      acc;
    longint      y;
    int unsigned idx;
    fir_out_t    r;
    sample_history[history_slot] = samp_t'(2 * int'(b) - 255);
    acc = 0;
    for (int unsigned k = 0; k < Taps; k++) begin
      idx = (history_slot + Taps - k) % Taps;
      acc += longint'(FirCoef[k]) * longint'(sample_history[idx]);
    end
    history_slot = (history_slot + 1) % Taps;
    if (acc >= 0) y = acc / OutDiv;
    else y = -((-acc + OutDiv - 1) / OutDiv);
    y += 128;
    if (y < 0) y = 0;
    if (y > 255) y = 255;
    r.filtered_byte = y[ByteW-1:0];
    r.last_out      = last;
    return r;
  endfunction

  // present one byte from a falling edge, hold it until the transfer, record the expectation
  task automatic send_sample(input logic [ByteW-1:0] b, input logic last,
                             input bit has_exp, input logic [ByteW-1:0] exp_byte);
    fir_out_t r;
    while (stall_enable && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = fir_filter_step(b, last);
    // rows with a hand-read value override the predictor, state still advances
    if (has_exp) r.filtered_byte = exp_byte;
    expected_bytes.push_back(r);
    @(negedge clk_i);
  endtask

  // output side backpressure, changed only at falling edges
  always @(negedge clk_i) begin
    m_axis_tready_i <= !(stall_enable && $urandom_range(99) < IdlePct);
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    fir_out_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d last %0b",
                                  m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        e = expected_bytes.pop_front();
        if (m_axis_tdata_o !== e.filtered_byte)
          report_mismatch($sformatf("filtered_byte %0d, want %0d",
                                    m_axis_tdata_o, e.filtered_byte));
        if (m_axis_tlast_o !== e.last_out)
          report_mismatch($sformatf("last_out %0b, want %0b",
                                    m_axis_tlast_o, e.last_out));
      end
    end
  end

  // directed rows: codes at the field extremes, bit patterns, buffer ends mid-stream
  dir_row_t dir_rows [] = '{
    '{8'd0,   1'b0, 1'b1, 8'd127},  // first byte after reset: -255 * 409 floors to -1
    '{8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd255, 1'b1, 1'b0, 8'd0},    // buffer end must not clear the history
    '{8'd0,   1'b0, 1'b0, 8'd0},
    '{8'd128, 1'b0, 1'b0, 8'd0},
    '{8'd127, 1'b0, 1'b0, 8'd0},
    '{8'd1,   1'b0, 1'b0, 8'd0},
    '{8'd254, 1'b1, 1'b0, 8'd0},
    '{8'h55,  1'b0, 1'b0, 8'd0},
    '{8'hAA,  1'b0, 1'b0, 8'd0},
    '{8'h0F,  1'b0, 1'b0, 8'd0},
    '{8'hF0,  1'b0, 1'b0, 8'd0},
    '{8'h80,  1'b1, 1'b0, 8'd0},
    '{8'h7F,  1'b1, 1'b0, 8'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd0,   1'b0, 1'b0, 8'd0},
    '{8'd255, 1'b0, 1'b0, 8'd0},
    '{8'd0,   1'b1, 1'b0, 8'd0},
    '{8'd64,  1'b0, 1'b0, 8'd0},
    '{8'd192, 1'b0, 1'b0, 8'd0}
  };

  initial begin
    int unsigned      sent;
    int unsigned      seg_len;
    int unsigned      mode;
    int               kk;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] hold_byte;
    logic             last;
    bit               pos;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    stall_enable    = 1'b1;
    history_slot    = 0;
    for (int i = 0; i < Taps; i++) sample_history[i] = '0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].sample_byte, dir_rows[i].last_in,
                  dir_rows[i].has_exp, dir_rows[i].exp_byte);

    // random segments; the middle stretch runs with no stalls on either side
    sent = 0;
    while (sent < RandItems) begin
      mode      = $urandom_range(99);
      seg_len   = (mode >= 60 && mode < 85) ? Taps : $urandom_range(40, 1);
      hold_byte = $urandom_range(1) ? 8'd255 : 8'd0;
      pos       = 1'($urandom_range(1));
      for (int j = 0; j < seg_len; j++) begin
        stall_enable = !(sent >= 150 && sent < 250);
        if (mode < 60) begin
          b = 8'($urandom_range(255));
        end else if (mode < 85) begin
          // oldest first, each byte pushed to the sign of its coefficient for peak sums
          kk = Taps - 1 - j;
          if (FirCoef[kk] == 0) b = 8'($urandom_range(255));
          else b = ((FirCoef[kk] > 0) == pos) ? 8'd255 : 8'd0;
        end else if (mode < 95) begin
          b = hold_byte;
        end else begin
          b = 8'd128 + 8'($urandom_range(6)) - 8'd3;
        end
        last = (j == seg_len - 1) || ($urandom_range(7) == 0);
        send_sample(b, last, 1'b0, 8'd0);
        sent++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
